[design/rmq_pkg.sv]
// Package of shared constants for the rotation matrix to quaternion block.
`default_nettype none
package rmq_pkg;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 14;

  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;
endpackage
`default_nettype wire

[design/rmq_if.sv]
// Handshake interfaces for the matrix input channel and the quaternion output channel.
`default_nettype none
interface rmq_in_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] qw, qx, qy, qz;
  logic [1:0] case_taken;
  logic degenerate;
  modport source (output valid, qw, qx, qy, qz, case_taken, degenerate, input ready);
  modport sink (input valid, qw, qx, qy, qz, case_taken, degenerate, output ready);
endinterface
`default_nettype wire

[design/rmq_sqrt_cell.sv]
// One cell of the square root chain: resolves one root bit per cycle while enabled.
`default_nettype none
module rmq_sqrt_cell #(
  parameter int RW = 17,
  parameter int SW = 53
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [RW+1:0]   rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [2*RW-1:0]      rad_o,
  output logic [RW+1:0]        rem_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        side_o
);
  logic [RW+1:0] cur, trial;
  logic          take;

  always_comb begin
    cur   = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
    trial = {root_i, 2'b01};
    take  = (cur >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[2*RW-3:0], 2'b00};
      rem_o  <= take ? (cur - trial) : cur;
      root_o <= {root_i[RW-2:0], take};
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

[design/rmq_div_cell.sv]
// One cell of the divider chain: resolves one quotient bit for each of three lanes.
`default_nettype none
module rmq_div_cell #(
  parameter int RW = 17,
  parameter int QW = 30,
  parameter int SW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [RW-1:0] root_i,
  input  wire logic [RW+1:0] rem_i [3],
  input  wire logic [QW-1:0] acc_i [3],
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [RW-1:0]      root_o,
  output logic [RW+1:0]      rem_o [3],
  output logic [QW-1:0]      acc_o [3],
  output logic [SW-1:0]      side_o
);
  logic [RW+1:0] dvs;
  logic [RW+1:0] cur  [3];
  logic          take [3];

  always_comb begin
    dvs = {1'b0, root_i, 1'b0};
    for (int l = 0; l < 3; l++) begin
      cur[l]  = {rem_i[l][RW:0], acc_i[l][QW-1]};
      take[l] = (cur[l] >= dvs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_o <= root_i;
      side_o <= side_i;
      for (int l = 0; l < 3; l++) begin
        rem_o[l] <= take[l] ? (cur[l] - dvs) : cur[l];
        acc_o[l] <= {acc_i[l][QW-2:0], take[l]};
      end
    end
  end
endmodule
`default_nettype wire

[design/rotation_matrix_to_quaternion_top.sv]
// Top level of the rotation matrix to quaternion converter.
`default_nettype none
// The block takes one 3x3 rotation matrix per item and returns the matching quaternion
// using the four-case method: the trace branch when the trace is positive, otherwise the
// branch of the largest diagonal entry. A front register selects the branch and forms the
// root argument and the three numerators. A chain of RW square root cells follows, each
// resolving one root bit, with RW = (max(DATA_WIDTH,FRAC_BITS)+3+FRAC_BITS+1)/2. Then a
// chain of QW = DATA_WIDTH+1+FRAC_BITS divider cells resolves one quotient bit per cycle while
// the chain advances, in three lanes at once. A final stage saturates and orders the components
// into a two-entry output buffer. One item is accepted every cycle while the chain advances.
// While the output side stalls the buffer takes items until both entries are full, after which
// the whole chain holds. A root of zero flags the result degenerate with zero components.
module rotation_matrix_to_quaternion_top #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  rmq_in_if.sink   in_i,
  rmq_out_if.source out_o
);
  localparam int DW  = DATA_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int AW  = ((DW > FB) ? DW : FB) + 3;  // clamped argument width
  localparam int NW  = AW + FB;                     // radicand width
  localparam int RW  = (NW + 1) / 2;                // root width
  localparam int GW  = DW + 1;                      // numerator magnitude width
  localparam int QW  = GW + FB;                     // dividend width
  localparam int SW1 = 5 + 3 * GW;                  // sel, signs, magnitudes
  localparam int SW2 = 5;                           // sel, signs
  localparam int OW  = 4 * DW + 3;

  // Global advance: the chain moves when the output buffer has room or is being read.
  logic [1:0] cnt_q;
  logic       en;
  assign en = (cnt_q != 2'd2) || out_o.ready;
  assign in_i.ready = en;

  // Front stage: branch selection and argument forming.
  logic signed [AW:0] a00, a11, a22, tr, arg;
  logic signed [DW:0] n0, n1, n2;
  logic [1:0]         sel;
  logic [2*RW-1:0]    rad;
  logic [DW:0]        g0, g1, g2;

  function automatic logic signed [DW:0] sx(input logic signed [DW-1:0] v);
    return {v[DW-1], v};
  endfunction

  // A sum of two most negative entries needs the full DW+1 bits of magnitude.
  function automatic logic [DW:0] mag(input logic signed [DW:0] v);
    return v[DW] ? -v : v;
  endfunction

  always_comb begin
    a00 = (AW+1)'(in_i.m00);
    a11 = (AW+1)'(in_i.m11);
    a22 = (AW+1)'(in_i.m22);
    tr  = a00 + a11 + a22;
    if (tr > 0) begin
      sel = rmq_pkg::SEL_TRACE;
      arg = tr;
      n0 = sx(in_i.m21) - sx(in_i.m12);
      n1 = sx(in_i.m02) - sx(in_i.m20);
      n2 = sx(in_i.m10) - sx(in_i.m01);
    end else if (a00 > a11 && a00 > a22) begin
      sel = rmq_pkg::SEL_X;
      arg = a00 - a11 - a22;
      n0 = sx(in_i.m21) - sx(in_i.m12);
      n1 = sx(in_i.m01) + sx(in_i.m10);
      n2 = sx(in_i.m02) + sx(in_i.m20);
    end else if (a11 > a22) begin
      sel = rmq_pkg::SEL_Y;
      arg = a11 - a00 - a22;
      n0 = sx(in_i.m02) - sx(in_i.m20);
      n1 = sx(in_i.m01) + sx(in_i.m10);
      n2 = sx(in_i.m12) + sx(in_i.m21);
    end else begin
      sel = rmq_pkg::SEL_Z;
      arg = a22 - a00 - a11;
      n0 = sx(in_i.m10) - sx(in_i.m01);
      n1 = sx(in_i.m02) + sx(in_i.m20);
      n2 = sx(in_i.m12) + sx(in_i.m21);
    end
    arg = arg + ((AW+1)'(1) <<< FB);
    if (arg < 0) begin
      arg = '0;
    end
    rad = (2*RW)'({arg[AW-1:0], {FB{1'b0}}});
    g0 = mag(n0);
    g1 = mag(n1);
    g2 = mag(n2);
  end

  logic            f_valid_q;
  logic [2*RW-1:0] f_rad_q;
  logic [SW1-1:0]  f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rad_q  <= rad;
      f_side_q <= {sel, n0[DW], n1[DW], n2[DW], g0, g1, g2};
    end
  end

  // Square root chain.
  logic            s_valid [RW+1];
  logic [2*RW-1:0] s_rad   [RW+1];
  logic [RW+1:0]   s_rem   [RW+1];
  logic [RW-1:0]   s_root  [RW+1];
  logic [SW1-1:0]  s_side  [RW+1];

  assign s_valid[0] = f_valid_q;
  assign s_rad[0]   = f_rad_q;
  assign s_rem[0]   = '0;
  assign s_root[0]  = '0;
  assign s_side[0]  = f_side_q;

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.RW(RW), .SW(SW1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s_valid[i]),
      .rad_i   (s_rad[i]),
      .rem_i   (s_rem[i]),
      .root_i  (s_root[i]),
      .side_i  (s_side[i]),
      .valid_o (s_valid[i+1]),
      .rad_o   (s_rad[i+1]),
      .rem_o   (s_rem[i+1]),
      .root_o  (s_root[i+1]),
      .side_o  (s_side[i+1])
    );
  end

  // Divider chain, three lanes sharing the divisor 2R.
  logic           d_valid [QW+1];
  logic [RW-1:0]  d_root  [QW+1];
  logic [RW+1:0]  d_rem   [QW+1][3];
  logic [QW-1:0]  d_acc   [QW+1][3];
  logic [SW2-1:0] d_side  [QW+1];
  logic [SW1-1:0] sv;

  assign sv         = s_side[RW];
  assign d_valid[0] = s_valid[RW];
  assign d_root[0]  = s_root[RW];
  assign d_side[0]  = sv[SW1-1 -: SW2];
  assign d_rem[0][0] = '0;
  assign d_rem[0][1] = '0;
  assign d_rem[0][2] = '0;
  assign d_acc[0][0] = {sv[3*GW-1 -: GW], {FB{1'b0}}};
  assign d_acc[0][1] = {sv[2*GW-1 -: GW], {FB{1'b0}}};
  assign d_acc[0][2] = {sv[GW-1:0], {FB{1'b0}}};

  for (genvar i = 0; i < QW; i++) begin : g_div
    rmq_div_cell #(.RW(RW), .QW(QW), .SW(SW2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d_valid[i]),
      .root_i  (d_root[i]),
      .rem_i   (d_rem[i]),
      .acc_i   (d_acc[i]),
      .side_i  (d_side[i]),
      .valid_o (d_valid[i+1]),
      .root_o  (d_root[i+1]),
      .rem_o   (d_rem[i+1]),
      .acc_o   (d_acc[i+1]),
      .side_o  (d_side[i+1])
    );
  end

  // Final stage: saturation and component ordering.
  function automatic logic [DW-1:0] sat(input logic neg, input logic [QW-1:0] q);
    logic [DW-1:0] r;
    if (!neg) begin
      r = (q > QW'((64'd1 << (DW-1)) - 64'd1)) ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
    end else begin
      r = (q > QW'(64'd1 << (DW-1))) ? {1'b1, {(DW-1){1'b0}}} : DW'(-q);
    end
    return r;
  endfunction

  logic [DW-1:0]  c0, c1, c2, cm, ow, ox, oy, oz;
  logic [1:0]     fsel;
  logic           dgn;
  logic [RW-1:0]  froot;
  logic [RW-1:0]  half;
  logic [OW-1:0]  res;

  always_comb begin
    fsel  = d_side[QW][4:3];
    froot = d_root[QW];
    dgn   = (froot == '0);
    c0 = sat(d_side[QW][2], d_acc[QW][0]);
    c1 = sat(d_side[QW][1], d_acc[QW][1]);
    c2 = sat(d_side[QW][0], d_acc[QW][2]);
    half = froot >> 1;
    if (RW > DW - 1 && (half >> (DW - 1)) != '0) begin
      cm = {1'b0, {(DW-1){1'b1}}};
    end else begin
      cm = DW'(half);
    end
    case (fsel)
      rmq_pkg::SEL_TRACE: begin ow = cm; ox = c0; oy = c1; oz = c2; end
      rmq_pkg::SEL_X:     begin ow = c0; ox = cm; oy = c1; oz = c2; end
      rmq_pkg::SEL_Y:     begin ow = c0; ox = c1; oy = cm; oz = c2; end
      default:            begin ow = c0; ox = c1; oy = c2; oz = cm; end
    endcase
    if (dgn) begin
      ow = '0; ox = '0; oy = '0; oz = '0;
    end
    res = {ow, ox, oy, oz, fsel, dgn};
  end

  // Two-entry output buffer.
  logic [OW-1:0] b0_q, b1_q;
  logic          push, pop;
  logic [1:0]    slot;

  assign push = d_valid[QW] && en;
  assign pop  = (cnt_q != 2'd0) && out_o.ready;
  assign slot = cnt_q - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && cnt_q == 2'd2) begin
      b0_q <= b1_q;
    end
    if (push) begin
      if (slot == 2'd0) begin
        b0_q <= res;
      end else begin
        b1_q <= res;
      end
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.qw         = b0_q[OW-1 -: DW];
  assign out_o.qx         = b0_q[OW-DW-1 -: DW];
  assign out_o.qy         = b0_q[OW-2*DW-1 -: DW];
  assign out_o.qz         = b0_q[OW-3*DW-1 -: DW];
  assign out_o.case_taken = b0_q[2:1];
  assign out_o.degenerate = b0_q[0];
endmodule
`default_nettype wire
